// ===== hw/rtl/tcce_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the text console engine.
package tcce_pkg;

	// Default screen geometry.
	localparam int unsigned SCREEN_COLUMNS_DEF = 80;
	localparam int unsigned SCREEN_ROWS_DEF    = 25;

	// Fixed field widths of the channels and the color register.
	localparam int unsigned OPCODE_W  = 2;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned RROW_W    = 5;
	localparam int unsigned RCOL_W    = 7;
	localparam int unsigned CELL_W    = 16;
	localparam int unsigned POS_W     = 11;
	localparam int unsigned COLOR_W   = 8;

	// Operation codes.
	localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

	// Control characters handled by a put, and the space that fills blank cells.
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	// Tab stops fall on multiples of this many columns.
	localparam int unsigned TAB_STEP = 8;

	// Attribute after reset and the blank cell that the store holds after reset.
	localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
	localparam logic [CELL_W-1:0]  BLANK_RESET = {COLOR_RESET, CH_SPACE};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap;        // capture the accepted input beat
		logic prep;       // resolve target row and column
		logic addr;       // form the cell address
		logic exec;       // cell write or read, cursor update
		logic fill_row;   // set up blanking of the row scrolled in
		logic fill_all;   // set up blanking of the whole screen
		logic fill_step;  // write one blank cell
		logic load_out;   // load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_clear;
		logic need_scroll;
		logic fill_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/tcce_ifs.sv =====
// Valid/ready channel interfaces for console requests and results.
interface tcce_req_if;
	logic                           valid;
	logic                           ready;
	logic [tcce_pkg::OPCODE_W-1:0]  opcode;
	logic [tcce_pkg::CHAR_W-1:0]    char_code;
	logic [tcce_pkg::RROW_W-1:0]    read_row;
	logic [tcce_pkg::RCOL_W-1:0]    read_col;

	modport source (output valid, output opcode, output char_code, output read_row,
		output read_col, input ready);
	modport sink (input valid, input opcode, input char_code, input read_row,
		input read_col, output ready);
endinterface

interface tcce_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tcce_pkg::CELL_W-1:0]    cell_value;
	logic [tcce_pkg::POS_W-1:0]     cursor_pos;

	modport source (output valid, output cell_value, output cursor_pos, input ready);
	modport sink (input valid, input cell_value, input cursor_pos, output ready);
endinterface

// ===== hw/rtl/tcce_ctrl.sv =====
// Sequencing state machine of the text console engine.
module tcce_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tcce_pkg::sts_t sts,
	output tcce_pkg::cmd_t cmd
);
	import tcce_pkg::*;

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_ADDR = 3'd3;
	localparam logic [2:0] ST_EXEC = 3'd4;
	localparam logic [2:0] ST_FILL = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.op_clear) begin
					cmd.fill_all = 1'b1;
					state_d      = ST_FILL;
				end else if (sts.need_scroll) begin
					cmd.fill_row = 1'b1;
					state_d      = ST_FILL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass over the cell store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Once the clearing pass has ended it never comes back.
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_INIT |=> state_q != ST_INIT)
		else $error("reset clearing pass reentered");

	// A result is only loaded when the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over a waiting beat");

endmodule

// ===== hw/rtl/tcce_datapath.sv =====
// Cell store, cursor, scroll offset and result register of the text console engine.
module tcce_datapath #(
	parameter int unsigned SCREEN_COLUMNS = tcce_pkg::SCREEN_COLUMNS_DEF,
	parameter int unsigned SCREEN_ROWS    = tcce_pkg::SCREEN_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcce_pkg::cmd_t                cmd,
	output tcce_pkg::sts_t                sts,
	input  logic                          cfg_wr_en,
	input  logic [tcce_pkg::COLOR_W-1:0]  cfg_wr_data,
	input  logic [tcce_pkg::OPCODE_W-1:0] req_opcode,
	input  logic [tcce_pkg::CHAR_W-1:0]   req_char_code,
	input  logic [tcce_pkg::RROW_W-1:0]   req_read_row,
	input  logic [tcce_pkg::RCOL_W-1:0]   req_read_col,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [tcce_pkg::CELL_W-1:0]   rsp_cell_value,
	output logic [tcce_pkg::POS_W-1:0]    rsp_cursor_pos
);
	import tcce_pkg::*;

	localparam int unsigned COL_W  = $clog2(SCREEN_COLUMNS);
	localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
	localparam int unsigned CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int unsigned ADDR_W = $clog2(CELLS);

	localparam logic [COL_W:0]      COLS_X    = (COL_W+1)'(SCREEN_COLUMNS);
	localparam logic [ROW_W:0]      ROWS_X    = (ROW_W+1)'(SCREEN_ROWS);
	localparam logic [ROW_W-1:0]    LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [ADDR_W-1:0]   COLS_A    = ADDR_W'(SCREEN_COLUMNS);
	localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(CELLS - 1);
	localparam logic [COL_W:0]      TAB_X     = (COL_W+1)'(TAB_STEP);
	localparam logic [COL_W:0]      TAB_MASK  = ~((COL_W+1)'(TAB_STEP - 1));
	localparam logic [RROW_W+1:0]   ROWS_R    = (RROW_W+2)'(SCREEN_ROWS);
	localparam logic [RCOL_W:0]     COLS_R    = (RCOL_W+1)'(SCREEN_COLUMNS);

	// Configuration and captured item.
	logic [COLOR_W-1:0]  color_q;
	logic [OPCODE_W-1:0] opcode_q;
	logic [CHAR_W-1:0]   char_q;
	logic [RROW_W-1:0]   rrow_q;
	logic [RCOL_W-1:0]   rcol_q;

	// Cursor and the physical row that holds logical row zero.
	logic [COL_W-1:0]    cursor_col_q;
	logic [ROW_W-1:0]    cursor_row_q;
	logic [ROW_W-1:0]    top_q;
	logic [ADDR_W-1:0]   top_base_q;

	// Address pipeline.
	logic [ROW_W-1:0]    phys_row_s1;
	logic [COL_W-1:0]    col_s1;
	logic                wr_en_s1;
	logic                blank_s1;
	logic                rd_en_s1;
	logic [ADDR_W-1:0]   addr_q;

	// Blanking sweep.
	logic [ADDR_W-1:0]   fill_addr_q;
	logic [ADDR_W-1:0]   fill_end_q;
	logic                fill_init_q;

	// Cell store and result register.
	logic [CELL_W-1:0]   mem [CELLS];
	logic [CELL_W-1:0]   rdata_q;
	logic                out_valid_q;
	logic [CELL_W-1:0]   cell_q;
	logic [POS_W-1:0]    pos_q;

	logic                is_put;
	logic                is_read;
	logic                is_clear;
	logic                is_bs;
	logic                in_range;
	logic [COL_W:0]      col_x;
	logic [COL_W:0]      col_inc;
	logic [COL_W:0]      col_tab;
	logic [ROW_W:0]      row_inc;
	logic [COL_W:0]      nxt_col_x;
	logic [ROW_W:0]      nxt_row_x;
	logic                wr_item;
	logic                wr_blank;
	logic                need_scroll;
	logic [ROW_W-1:0]    targ_row;
	logic [COL_W-1:0]    targ_col;
	logic [ROW_W:0]      phys_sum;
	logic [ROW_W:0]      phys_x;
	logic [CELL_W-1:0]   blank_cell;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [CELL_W-1:0]   mem_wdata;
	logic                fill_last;

	// Item decode.
	assign is_put     = (opcode_q == OP_PUT);
	assign is_read    = (opcode_q == OP_READ);
	assign is_clear   = (opcode_q == OP_CLEAR);
	assign is_bs      = is_put && (char_q == CH_BACKSPACE);
	assign in_range   = ({2'b00, rrow_q} < ROWS_R) && ({1'b0, rcol_q} < COLS_R);
	assign blank_cell = {color_q, CH_SPACE};

	// Cursor movement for a put.
	assign col_x   = {1'b0, cursor_col_q};
	assign col_inc = col_x + (COL_W+1)'(1);
	assign col_tab = (col_x + TAB_X) & TAB_MASK;
	assign row_inc = {1'b0, cursor_row_q} + (ROW_W+1)'(1);

	always_comb begin
		nxt_col_x = col_x;
		nxt_row_x = {1'b0, cursor_row_q};
		wr_item   = 1'b0;
		wr_blank  = 1'b0;
		if (is_put) begin
			unique case (char_q)
				CH_NEWLINE: begin
					nxt_col_x = '0;
					nxt_row_x = row_inc;
				end
				CH_RETURN: begin
					nxt_col_x = '0;
				end
				CH_BACKSPACE: begin
					if (cursor_col_q != '0) begin
						nxt_col_x = col_x - (COL_W+1)'(1);
						wr_item   = 1'b1;
						wr_blank  = 1'b1;
					end
				end
				CH_TAB: begin
					if (col_tab >= COLS_X) begin
						nxt_col_x = '0;
						nxt_row_x = row_inc;
					end else begin
						nxt_col_x = col_tab;
					end
				end
				default: begin
					wr_item = 1'b1;
					if (col_inc >= COLS_X) begin
						nxt_col_x = '0;
						nxt_row_x = row_inc;
					end else begin
						nxt_col_x = col_inc;
					end
				end
			endcase
		end
	end

	assign need_scroll = is_put && (nxt_row_x == ROWS_X);

	// Target cell in screen coordinates, then rotated by the scroll offset.
	assign targ_row = is_read ? ROW_W'(rrow_q) : cursor_row_q;
	assign targ_col = is_read ? COL_W'(rcol_q) :
		(is_bs ? cursor_col_q - COL_W'(1) : cursor_col_q);
	assign phys_sum = {1'b0, targ_row} + {1'b0, top_q};
	assign phys_x   = (phys_sum >= ROWS_X) ? phys_sum - ROWS_X : phys_sum;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (cfg_wr_en) begin
			color_q <= cfg_wr_data;
		end
	end

	// Capture of the accepted beat.
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			opcode_q <= req_opcode;
			char_q   <= req_char_code;
			rrow_q   <= req_read_row;
			rcol_q   <= req_read_col;
		end
	end

	// Target resolution and address formation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
			blank_s1 <= 1'b0;
			rd_en_s1 <= 1'b0;
		end else if (cmd.prep) begin
			wr_en_s1 <= wr_item;
			blank_s1 <= wr_blank;
			rd_en_s1 <= is_read && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			phys_row_s1 <= ROW_W'(phys_x);
			col_s1      <= targ_col;
		end
		if (cmd.addr) begin
			addr_q <= ADDR_W'(ADDR_W'(phys_row_s1) * COLS_A + ADDR_W'(col_s1));
		end
	end

	// Cursor, scroll offset and blanking sweep control.
	assign fill_last = (fill_addr_q == fill_end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			top_q        <= '0;
			top_base_q   <= '0;
			fill_addr_q  <= '0;
			fill_end_q   <= LAST_ADDR;
			fill_init_q  <= 1'b1;
		end else begin
			if (cmd.exec) begin
				if (is_clear) begin
					cursor_col_q <= '0;
					cursor_row_q <= '0;
				end else if (is_put) begin
					cursor_col_q <= COL_W'(nxt_col_x);
					cursor_row_q <= need_scroll ? LAST_ROW : ROW_W'(nxt_row_x);
				end
			end
			if (cmd.fill_all) begin
				fill_addr_q <= '0;
				fill_end_q  <= LAST_ADDR;
				top_q       <= '0;
				top_base_q  <= '0;
			end else if (cmd.fill_row) begin
				// The old top row becomes the new bottom row.
				fill_addr_q <= top_base_q;
				fill_end_q  <= top_base_q + COLS_A - ADDR_W'(1);
				if (top_q == LAST_ROW) begin
					top_q      <= '0;
					top_base_q <= '0;
				end else begin
					top_q      <= top_q + ROW_W'(1);
					top_base_q <= top_base_q + COLS_A;
				end
			end else if (cmd.fill_step) begin
				if (fill_last) begin
					fill_init_q <= 1'b0;
				end else begin
					fill_addr_q <= fill_addr_q + ADDR_W'(1);
				end
			end
		end
	end

	// Single write port shared by item writes and the blanking sweep.
	assign mem_we    = (cmd.exec && wr_en_s1) || cmd.fill_step;
	assign mem_waddr = cmd.fill_step ? fill_addr_q : addr_q;
	assign mem_wdata = cmd.fill_step ? (fill_init_q ? BLANK_RESET : blank_cell) :
		(blank_s1 ? blank_cell : {color_q, char_q});

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.exec && rd_en_s1) begin
			rdata_q <= mem[addr_q];
		end
	end

	// Result register; it holds a beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_q <= rd_en_s1 ? rdata_q : '0;
			pos_q  <= POS_W'(ADDR_W'(ADDR_W'(cursor_row_q) * COLS_A
				+ ADDR_W'(cursor_col_q)));
		end
	end

	assign rsp_valid      = out_valid_q;
	assign rsp_cell_value = cell_q;
	assign rsp_cursor_pos = pos_q;

	// Status to the controller.
	assign sts.op_clear    = is_clear;
	assign sts.need_scroll = need_scroll;
	assign sts.fill_last   = fill_last;
	assign sts.out_free    = !out_valid_q || rsp_ready;

	// The cursor stays on the screen between items.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cursor_col_q} < COLS_X) && ({1'b0, cursor_row_q} < ROWS_X))
		else $error("cursor left the screen");

	// The row base tracks the top row index.
	a_top_base: assert property (@(posedge clk) disable iff (!arst_n)
		top_base_q == ADDR_W'(ADDR_W'(top_q) * COLS_A))
		else $error("scroll base out of step with top row");

	// The blanking sweep never runs past its last cell.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_addr_q <= fill_end_q)
		else $error("blanking sweep overran its end");

endmodule

// ===== hw/rtl/text_console_cursor_engine_unit.sv =====
// Top level of the text console engine: request and result channels and the color register.
//
//   channel      dir   beat contents                               handshake
//   req          in    opcode, char_code, read_row, read_col       valid/ready
//   rsp          out   cell_value, cursor_pos                      valid/ready
//   cfg_wr_*     in    text color attribute                        write enable
//
// An item goes through these steps from acceptance to its result beat, and the next item is
// accepted only after that beat is loaded: capture, row rotation, address multiply, cell
// access in the cell store, result load.
// A put that scrolls also blanks the new row, and a clear blanks every cell.
// Scrolling itself is a row offset and moves no data.
// After reset the block sweeps the whole cell store, one cell a cycle, before it takes the first item.
// A stalled result beat waits in the output register while the next item is worked.
module text_console_cursor_engine_unit #(
	parameter int unsigned SCREEN_COLUMNS = tcce_pkg::SCREEN_COLUMNS_DEF,
	parameter int unsigned SCREEN_ROWS    = tcce_pkg::SCREEN_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tcce_req_if.sink                     req,
	tcce_rsp_if.source                   rsp,
	input  logic                         cfg_wr_en,
	input  logic [tcce_pkg::COLOR_W-1:0] cfg_wr_data
);
	import tcce_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	tcce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Cell store, cursor and result register.
	tcce_datapath #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.req_opcode     (req.opcode),
		.req_char_code  (req.char_code),
		.req_read_row   (req.read_row),
		.req_read_col   (req.read_col),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_cell_value (rsp.cell_value),
		.rsp_cursor_pos (rsp.cursor_pos)
	);

endmodule
